// ===== rtl/core/blq_pkg.sv =====
// ----------------------------------------------------------------------------
// blq_pkg
// Shared types and codes for the battery level qualifier.
// ----------------------------------------------------------------------------
package blq_pkg;

   typedef logic [1:0]  health_type;
   typedef logic        func_type;
   typedef logic        csr_index_type;
   typedef logic [15:0] mv_type;
   typedef logic [7:0]  count_type;

   localparam health_type CLASS_INVALID    = 2'd0;
   localparam health_type CLASS_PRECHARGE  = 2'd1;
   localparam health_type CLASS_DEEP_DISCH = 2'd2;
   localparam health_type CLASS_NORMAL     = 2'd3;

   localparam func_type FUNC_SAMPLE     = 1'b0;
   localparam func_type FUNC_READ_CLEAR = 1'b1;

   localparam csr_index_type CSR_VSET     = 1'b0;
   localparam csr_index_type CSR_DEBOUNCE = 1'b1;

   localparam count_type DEFAULT_DEBOUNCE = 8'd5;

   // thresholds and control handed from the register block to the core
   typedef struct packed {
      logic [13:0] t20;
      logic [14:0] t40;
      logic [15:0] t65;
      count_type   limit;
      logic        vset_wr;
   } blq_cfg_type;

endpackage

// ===== rtl/core/blq_req_if.sv =====
// ----------------------------------------------------------------------------
// blq_req_if
// Request channel: sample words and flag read/clear words.
// ----------------------------------------------------------------------------
interface blq_req_if
   import blq_pkg::*;
();
   logic     valid;
   logic     ready;
   func_type func;
   mv_type   voltage_mv;

   modport source (output valid, output func, output voltage_mv, input ready);
   modport sink   (input valid, input func, input voltage_mv, output ready);
endinterface

// ===== rtl/core/blq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// blq_rsp_if
// Response channel: adopted class, qualification and flag state.
// ----------------------------------------------------------------------------
interface blq_rsp_if
   import blq_pkg::*;
();
   logic       valid;
   logic       ready;
   health_type health;
   logic       qualified;
   mv_type     last_voltage_mv;
   logic       changed;

   modport source (output valid, output health, output qualified,
                   output last_voltage_mv, output changed, input ready);
   modport sink   (input valid, input health, input qualified,
                   input last_voltage_mv, input changed, output ready);
endinterface

// ===== rtl/core/blq_csr_if.sv =====
// ----------------------------------------------------------------------------
// blq_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface blq_csr_if
   import blq_pkg::*;
();
   logic          valid;
   logic          ready;
   csr_index_type index;
   logic [15:0]   wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/blq_csr.sv =====
// ----------------------------------------------------------------------------
// blq_csr
// Register block: set voltage thresholds (20/40/65 percent) and debounce limit.
// ----------------------------------------------------------------------------
module blq_csr
   import blq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   blq_csr_if.sink      csr_bus,
   output blq_cfg_type  cfg
);

   logic [13:0] t20_ff, t20_in;
   logic [14:0] t40_ff, t40_in;
   logic [15:0] t65_ff, t65_in;
   count_type   limit_ff, limit_in;

   logic        wr;
   logic [31:0] prod;
   logic [13:0] q;
   logic [15:0] q5;
   logic [2:0]  r;
   logic [3:0]  r13;
   logic [17:0] s65;

   assign csr_bus.ready = 1'b1;
   assign wr = csr_bus.valid & csr_bus.ready;

   // v/5 by reciprocal, exact for 16-bit v
   assign prod = {16'd0, csr_bus.wdata} * 32'h0000_CCCD;
   assign q    = prod[31:18];
   assign q5   = {q, 2'b00} + {2'b00, q};
   assign r    = 3'(csr_bus.wdata - q5);

   // floor(13*r/5) for r < 5
   always_comb begin
      case (r)
         3'd1:    r13 = 4'd2;
         3'd2:    r13 = 4'd5;
         3'd3:    r13 = 4'd7;
         3'd4:    r13 = 4'd10;
         default: r13 = 4'd0;
      endcase
   end

   assign s65 = ({4'd0, q} << 3) + ({4'd0, q} << 2) + {4'd0, q} + {14'd0, r13};

   always_comb begin
      t20_in   = t20_ff;
      t40_in   = t40_ff;
      t65_in   = t65_ff;
      limit_in = limit_ff;
      if (wr) begin
         unique case (csr_bus.index)
            CSR_VSET: begin
               t20_in = q;
               t40_in = {q, 1'b0} + {14'd0, (r >= 3'd3)};
               t65_in = s65[17:2];
            end
            CSR_DEBOUNCE: begin
               limit_in = csr_bus.wdata[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t20_ff   <= '0;
         t40_ff   <= '0;
         t65_ff   <= '0;
         limit_ff <= DEFAULT_DEBOUNCE;
      end else begin
         t20_ff   <= t20_in;
         t40_ff   <= t40_in;
         t65_ff   <= t65_in;
         limit_ff <= limit_in;
      end
   end

   assign cfg.t20     = t20_ff;
   assign cfg.t40     = t40_ff;
   assign cfg.t65     = t65_ff;
   assign cfg.limit   = (limit_ff == 8'd0) ? DEFAULT_DEBOUNCE : limit_ff;
   assign cfg.vset_wr = wr && (csr_bus.index == CSR_VSET);

endmodule

// ===== rtl/core/blq_core.sv =====
// ----------------------------------------------------------------------------
// blq_core
// Classifier, debounce and qualification state with registered response.
// ----------------------------------------------------------------------------
module blq_core
   import blq_pkg::*;
#(
   parameter int QUALIFY_SAMPLES = 600
) (
   input  logic         clock,
   input  logic         reset,
   blq_req_if.sink      req_bus,
   blq_rsp_if.source    rsp_bus,
   input  blq_cfg_type  cfg
);

   localparam int TICK_W = $clog2(QUALIFY_SAMPLES + 1);
   localparam logic [TICK_W-1:0] QTICKS = TICK_W'(QUALIFY_SAMPLES);

   health_type        class_ff, class_in;
   count_type         mm_ff, mm_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;
   logic              qual_ff, qual_in;
   logic              chg_ff, chg_in;
   mv_type            latest_ff, latest_in;

   logic              rsp_valid_ff, rsp_valid_in;
   health_type        rsp_health_ff, rsp_health_in;
   logic              rsp_qual_ff, rsp_qual_in;
   mv_type            rsp_mv_ff, rsp_mv_in;
   logic              rsp_chg_ff, rsp_chg_in;

   logic              accept;
   health_type        cls;
   count_type         mm_inc;
   logic              adopt;
   logic [TICK_W-1:0] ticks_base;

   assign req_bus.ready = ~rsp_valid_ff | rsp_bus.ready;
   assign accept        = req_bus.valid & req_bus.ready;

   always_comb begin
      if ({1'b0, req_bus.voltage_mv} >= {1'b0, cfg.t65}) begin
         cls = CLASS_NORMAL;
      end else if (req_bus.voltage_mv >= {1'b0, cfg.t40}) begin
         cls = CLASS_DEEP_DISCH;
      end else if (req_bus.voltage_mv >= {2'b00, cfg.t20}) begin
         cls = CLASS_PRECHARGE;
      end else begin
         cls = CLASS_INVALID;
      end
   end

   assign mm_inc     = (mm_ff == 8'hFF) ? mm_ff : mm_ff + 8'd1;
   assign adopt      = (cls != class_ff) && (mm_inc >= cfg.limit);
   assign ticks_base = adopt ? '0 : ticks_ff;

   always_comb begin
      class_in  = class_ff;
      mm_in     = mm_ff;
      ticks_in  = ticks_ff;
      qual_in   = qual_ff;
      chg_in    = chg_ff;
      latest_in = latest_ff;
      if (accept) begin
         if (req_bus.func == FUNC_SAMPLE) begin
            latest_in = req_bus.voltage_mv;
            if (cls == class_ff) begin
               mm_in = '0;
            end else if (adopt) begin
               class_in = cls;
               chg_in   = 1'b1;
               mm_in    = '0;
            end else begin
               mm_in = mm_inc;
            end
            ticks_in = (ticks_base < QTICKS) ? ticks_base + TICK_W'(1) : ticks_base;
            qual_in  = (ticks_in >= QTICKS) ? 1'b1 : (qual_ff & ~adopt);
         end else begin
            chg_in = 1'b0;
         end
      end
      if (cfg.vset_wr) begin
         ticks_in = '0;
         qual_in  = 1'b0;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in  = accept | (rsp_valid_ff & ~rsp_bus.ready);
      rsp_health_in = rsp_health_ff;
      rsp_qual_in   = rsp_qual_ff;
      rsp_mv_in     = rsp_mv_ff;
      rsp_chg_in    = rsp_chg_ff;
      if (accept) begin
         rsp_health_in = class_in;
         rsp_qual_in   = qual_in;
         rsp_mv_in     = latest_in;
         rsp_chg_in    = (req_bus.func == FUNC_SAMPLE) ? chg_in : chg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_ff     <= CLASS_INVALID;
         mm_ff        <= '0;
         ticks_ff     <= '0;
         qual_ff      <= 1'b0;
         chg_ff       <= 1'b0;
         latest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         class_ff     <= class_in;
         mm_ff        <= mm_in;
         ticks_ff     <= ticks_in;
         qual_ff      <= qual_in;
         chg_ff       <= chg_in;
         latest_ff    <= latest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_health_ff <= rsp_health_in;
      rsp_qual_ff   <= rsp_qual_in;
      rsp_mv_ff     <= rsp_mv_in;
      rsp_chg_ff    <= rsp_chg_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.health          = rsp_health_ff;
   assign rsp_bus.qualified       = rsp_qual_ff;
   assign rsp_bus.last_voltage_mv = rsp_mv_ff;
   assign rsp_bus.changed         = rsp_chg_ff;

   a_qual_tracks_ticks: assert property (@(posedge clock) disable iff (reset)
      qual_ff == (ticks_ff == QTICKS))
      else $error("qualified flag out of step with tick count");

   a_ticks_saturate: assert property (@(posedge clock) disable iff (reset)
      ticks_ff <= QTICKS)
      else $error("tick count beyond saturation");

   a_accept_gives_word: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no response");

   a_adopt_sets_changed: assert property (@(posedge clock) disable iff (reset)
      (class_ff != $past(class_ff)) |-> chg_ff)
      else $error("class adopted without changed flag");

endmodule

// ===== rtl/core/battery_level_qualifier_top.sv =====
// ----------------------------------------------------------------------------
// battery_level_qualifier_top
// Response: each accepted request word gives its response word in the next cycle.
// Throughput: one word per cycle while the response side takes each word; the response register frees as it is taken.
// Thresholds are computed in the register block from the written set voltage and registered.
// Reset: synchronous, active high; set voltage 0, debounce limit 5, state 0.
// ----------------------------------------------------------------------------
module battery_level_qualifier_top
   import blq_pkg::*;
#(
   parameter int QUALIFY_SAMPLES = 600
) (
   input  logic        clock,
   input  logic        reset,
   blq_req_if.sink     req_bus,
   blq_rsp_if.source   rsp_bus,
   blq_csr_if.sink     csr_bus
);

   blq_cfg_type cfg;

   blq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   blq_core #(
      .QUALIFY_SAMPLES (QUALIFY_SAMPLES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .cfg     (cfg)
   );

endmodule
